/* sv/lcabl_pkg.sv */
// Shared widths, defaults and shared-unit types for the binary-lifting ancestor block.
`timescale 1ns / 1ps
package lcabl_pkg;

    // Fixed field widths of node numbers and depths.
    localparam int NODE_W  = 10;
    localparam int DEPTH_W = 10;

    // Largest depth that can be stored; deeper nodes saturate here.
    localparam logic [DEPTH_W-1:0] DEPTH_MAX = '1;

    // Defaults for the top-level parameters.
    localparam int NODES_DEF  = 1024;
    localparam int LEVELS_DEF = 10;

    // Operation carried by an input transaction.
    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_QUERY  = 1'b1
    } opcode_t;

    // Operations of the shared compare/increment unit.
    typedef enum logic [2:0] {
        ALU_INC = 3'd0,
        ALU_LT  = 3'd1,
        ALU_GE  = 3'd2,
        ALU_NE  = 3'd3,
        ALU_EQ  = 3'd4
    } alu_op_t;

    typedef struct packed {
        alu_op_t           op;
        logic [NODE_W-1:0] x;
        logic [NODE_W-1:0] y;
    } alu_req_t;

    typedef struct packed {
        logic              flag;
        logic [NODE_W-1:0] sum;
    } alu_rsp_t;

endpackage

/* sv/lca_binary_lifting.sv */
// Top level of the binary-lifting lowest-common-ancestor block: sequencer and stores.
`timescale 1ns / 1ps
//
//  Channel  Direction  Handshake             Payload
//  -------  ---------  --------------------  ----------------------------------
//  in       input      in_valid / in_stall   opcode, first_node, second_node
//  out      output     out_valid / out_stall ancestor
//
// An insert walks I_ROOT and I_DEP, then I_ANC and I_WR per jump level below LEVELS;
// an insert of node 0 is accepted and leaves the block idle. A query reads both
// depths (Q_DEP, Q_SWAP), lifts the deeper node (U_ANC, U_DEP, U_CMP) and ends at
// Q_EQ when it meets the other one, else lifts both nodes (D_ANC, D_CMP) and reads
// the parent (F_ANC, F_OUT). Every jump level costs one dependent table read
// followed by a depth read and a compare, or a compare alone, in the shared unit.
// After reset the block sweeps both stores to zero, one ancestor entry per cycle,
// over all NODES*2^clog2(LEVELS+1) table entries; in_stall stays high during that
// sweep and while an item is being worked on.
// A finished result sits in the output register, so a stalled output does not
// stop the next input transaction from being accepted; the result of the query
// after it waits in the hand-over step, with in_stall high, until that register
// is read.
module lca_binary_lifting #(
    parameter int NODES  = lcabl_pkg::NODES_DEF,
    parameter int LEVELS = lcabl_pkg::LEVELS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic                         opcode,
    input  logic [lcabl_pkg::NODE_W-1:0] first_node,
    input  logic [lcabl_pkg::NODE_W-1:0] second_node,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [lcabl_pkg::NODE_W-1:0] ancestor
);

    import lcabl_pkg::*;

    // Address widths: a node row, a jump level inside the row, and both together.
    localparam int AW        = $clog2(NODES);
    localparam int LW        = $clog2(LEVELS + 1);
    localparam int CW        = AW + LW;
    localparam int ANC_DEPTH = NODES << LW;

    localparam logic [CW-1:0] CLR_LAST  = CW'(ANC_DEPTH - 1);
    localparam logic [LW-1:0] LVL_TOP   = LW'(LEVELS);
    localparam logic [LW-1:0] LVL_LAST  = LW'(LEVELS - 1);

    // Sequencer states. The insert walk uses I_*, the query first lifts the
    // deeper node (U_*), then lifts both nodes while they differ (D_*).
    typedef enum logic [16:0] {
        S_CLEAR  = 17'h00001,
        S_IDLE   = 17'h00002,
        S_I_ROOT = 17'h00004,
        S_I_DEP  = 17'h00008,
        S_I_ANC  = 17'h00010,
        S_I_WR   = 17'h00020,
        S_Q_DEP  = 17'h00040,
        S_Q_SWAP = 17'h00080,
        S_U_ANC  = 17'h00100,
        S_U_DEP  = 17'h00200,
        S_U_CMP  = 17'h00400,
        S_Q_EQ   = 17'h00800,
        S_D_ANC  = 17'h01000,
        S_D_CMP  = 17'h02000,
        S_F_ANC  = 17'h04000,
        S_F_OUT  = 17'h08000,
        S_DONE   = 17'h10000
    } state_t;

    // Node numbers at or above NODES stand for the sentinel, node 0.
    function automatic logic [NODE_W-1:0] node_index(input logic [NODE_W-1:0] v);
        logic [16:0] wide;
        wide = 17'(v);
        return (wide < 17'(NODES)) ? v : '0;
    endfunction

    // Stored node numbers are always below NODES, so this only resizes.
    function automatic logic [AW-1:0] to_addr(input logic [NODE_W-1:0] v);
        logic [16:0] wide;
        wide = 17'(v);
        return wide[AW-1:0];
    endfunction

    state_t              state_reg,  state_next;
    logic [CW-1:0]       clr_reg,    clr_next;
    logic                out_valid_reg, out_valid_next;
    logic [NODE_W-1:0]   ancestor_reg, ancestor_next;
    logic [NODE_W-1:0]   a_reg,      a_next;
    logic [NODE_W-1:0]   b_reg,      b_next;
    logic [DEPTH_W-1:0]  db_reg,     db_next;
    logic [NODE_W-1:0]   up_reg,     up_next;
    logic [LW-1:0]       lvl_reg,    lvl_next;
    logic [NODE_W-1:0]   result_reg, result_next;

    logic                in_accept;
    logic [NODE_W-1:0]   in_first;
    logic [NODE_W-1:0]   in_second;
    logic                slot_free;

    // Store ports.
    logic                dep_we;
    logic [AW-1:0]       dep_waddr;
    logic [DEPTH_W-1:0]  dep_wdata;
    logic [AW-1:0]       dep_raddr0;
    logic [AW-1:0]       dep_raddr1;
    logic [DEPTH_W-1:0]  dep_rd0;
    logic [DEPTH_W-1:0]  dep_rd1;
    logic                anc_we;
    logic [CW-1:0]       anc_waddr;
    logic [NODE_W-1:0]   anc_wdata;
    logic [CW-1:0]       anc_raddr0;
    logic [CW-1:0]       anc_raddr1;
    logic [NODE_W-1:0]   anc_rd0;
    logic [NODE_W-1:0]   anc_rd1;

    alu_req_t            alu_req;
    alu_rsp_t            alu_rsp;

    assign in_stall  = (state_reg != S_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign in_first  = node_index(first_node);
    assign in_second = node_index(second_node);
    assign out_valid = out_valid_reg;
    assign ancestor  = ancestor_reg;

    // The output register can take a new result when it is empty or being read.
    assign slot_free = !out_valid_reg || !out_stall;

    // Depth of every node, one entry per node.
    lcabl_ram #(
        .WIDTH (DEPTH_W),
        .DEPTH (NODES)
    ) u_depth_ram (
        .clk    (clk),
        .we     (dep_we),
        .waddr  (dep_waddr),
        .wdata  (dep_wdata),
        .raddr0 (dep_raddr0),
        .raddr1 (dep_raddr1),
        .rdata0 (dep_rd0),
        .rdata1 (dep_rd1)
    );

    // Ancestor table, addressed as {node, jump level}.
    lcabl_ram #(
        .WIDTH (NODE_W),
        .DEPTH (ANC_DEPTH)
    ) u_anc_ram (
        .clk    (clk),
        .we     (anc_we),
        .waddr  (anc_waddr),
        .wdata  (anc_wdata),
        .raddr0 (anc_raddr0),
        .raddr1 (anc_raddr1),
        .rdata0 (anc_rd0),
        .rdata1 (anc_rd1)
    );

    lcabl_alu u_alu (
        .req (alu_req),
        .rsp (alu_rsp)
    );

    // What the shared unit is asked to do in each step.
    always_comb
    begin
        alu_req.op = ALU_EQ;
        alu_req.x  = '0;
        alu_req.y  = '0;
        case (state_reg)
            S_I_DEP:
            begin
                // New depth is the parent's depth plus one, saturating.
                alu_req.op = ALU_INC;
                alu_req.x  = dep_rd0;
            end
            S_Q_SWAP:
            begin
                alu_req.op = ALU_LT;
                alu_req.x  = dep_rd0;
                alu_req.y  = dep_rd1;
            end
            S_U_CMP:
            begin
                alu_req.op = ALU_GE;
                alu_req.x  = dep_rd0;
                alu_req.y  = db_reg;
            end
            S_Q_EQ:
            begin
                alu_req.op = ALU_EQ;
                alu_req.x  = a_reg;
                alu_req.y  = b_reg;
            end
            S_D_CMP:
            begin
                alu_req.op = ALU_NE;
                alu_req.x  = anc_rd0;
                alu_req.y  = anc_rd1;
            end
            default:
            begin
                alu_req.op = ALU_EQ;
                alu_req.x  = '0;
                alu_req.y  = '0;
            end
        endcase
    end

    // Store addresses and writes. By default both stores read the rows of the
    // two working nodes at the current level.
    always_comb
    begin
        dep_we     = 1'b0;
        dep_waddr  = to_addr(a_reg);
        dep_wdata  = alu_rsp.sum;
        dep_raddr0 = to_addr(a_reg);
        dep_raddr1 = to_addr(b_reg);
        anc_we     = 1'b0;
        anc_waddr  = {to_addr(a_reg), lvl_reg};
        anc_wdata  = anc_rd0;
        anc_raddr0 = {to_addr(a_reg), lvl_reg};
        anc_raddr1 = {to_addr(b_reg), lvl_reg};
        case (state_reg)
            S_CLEAR:
            begin
                dep_we    = 1'b1;
                dep_waddr = clr_reg[CW-1:LW];
                dep_wdata = '0;
                anc_we    = 1'b1;
                anc_waddr = clr_reg;
                anc_wdata = '0;
            end
            S_I_ROOT:
            begin
                // Level 0 of the new node is its parent.
                anc_we     = 1'b1;
                anc_waddr  = {to_addr(a_reg), {LW{1'b0}}};
                anc_wdata  = b_reg;
                dep_raddr0 = to_addr(b_reg);
            end
            S_I_DEP:
            begin
                dep_we = 1'b1;
            end
            S_I_ANC:
            begin
                // b_reg walks the chain: the node's ancestor at the level below.
                anc_raddr0 = {to_addr(b_reg), lvl_reg};
            end
            S_I_WR:
            begin
                anc_we    = 1'b1;
                anc_waddr = {to_addr(a_reg), lvl_reg + 1'b1};
                anc_wdata = anc_rd0;
            end
            S_U_DEP:
            begin
                dep_raddr0 = to_addr(anc_rd0);
            end
            S_F_ANC:
            begin
                anc_raddr0 = {to_addr(a_reg), {LW{1'b0}}};
            end
            default:
            begin
                dep_we = 1'b0;
                anc_we = 1'b0;
            end
        endcase
    end

    // Sequencer.
    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        out_valid_next = out_valid_reg;
        ancestor_next  = ancestor_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        db_next        = db_reg;
        up_next        = up_reg;
        lvl_next       = lvl_reg;
        result_next    = result_reg;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_CLEAR:
            begin
                clr_next = clr_reg + 1'b1;
                if (clr_reg == CLR_LAST)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_accept)
                begin
                    a_next = in_first;
                    b_next = in_second;
                    if (opcode == OP_INSERT)
                    begin
                        // The sentinel is never overwritten.
                        if (in_first != '0)
                        begin
                            state_next = S_I_ROOT;
                        end
                    end
                    else
                    begin
                        state_next = S_Q_DEP;
                    end
                end
            end
            S_I_ROOT:
            begin
                state_next = S_I_DEP;
            end
            S_I_DEP:
            begin
                lvl_next   = '0;
                state_next = S_I_ANC;
            end
            S_I_ANC:
            begin
                state_next = S_I_WR;
            end
            S_I_WR:
            begin
                b_next   = anc_rd0;
                lvl_next = lvl_reg + 1'b1;
                if (lvl_reg == LVL_LAST)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_I_ANC;
                end
            end
            S_Q_DEP:
            begin
                state_next = S_Q_SWAP;
            end
            S_Q_SWAP:
            begin
                // Make a_reg the deeper node; db_reg keeps the other's depth.
                if (alu_rsp.flag)
                begin
                    a_next  = b_reg;
                    b_next  = a_reg;
                    db_next = dep_rd0;
                end
                else
                begin
                    db_next = dep_rd1;
                end
                lvl_next   = LVL_TOP;
                state_next = S_U_ANC;
            end
            S_U_ANC:
            begin
                state_next = S_U_DEP;
            end
            S_U_DEP:
            begin
                up_next    = anc_rd0;
                state_next = S_U_CMP;
            end
            S_U_CMP:
            begin
                if (alu_rsp.flag)
                begin
                    a_next = up_reg;
                end
                if (lvl_reg == '0)
                begin
                    state_next = S_Q_EQ;
                end
                else
                begin
                    lvl_next   = lvl_reg - 1'b1;
                    state_next = S_U_ANC;
                end
            end
            S_Q_EQ:
            begin
                if (alu_rsp.flag)
                begin
                    result_next = a_reg;
                    state_next  = S_DONE;
                end
                else
                begin
                    lvl_next   = LVL_TOP;
                    state_next = S_D_ANC;
                end
            end
            S_D_ANC:
            begin
                state_next = S_D_CMP;
            end
            S_D_CMP:
            begin
                if (alu_rsp.flag)
                begin
                    a_next = anc_rd0;
                    b_next = anc_rd1;
                end
                if (lvl_reg == '0)
                begin
                    state_next = S_F_ANC;
                end
                else
                begin
                    lvl_next   = lvl_reg - 1'b1;
                    state_next = S_D_ANC;
                end
            end
            S_F_ANC:
            begin
                state_next = S_F_OUT;
            end
            S_F_OUT:
            begin
                result_next = anc_rd0;
                state_next  = S_DONE;
            end
            S_DONE:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    ancestor_next  = result_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
                clr_next   = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ancestor_reg <= ancestor_next;
        a_reg        <= a_next;
        b_reg        <= b_next;
        db_reg       <= db_next;
        up_reg       <= up_next;
        lvl_reg      <= lvl_next;
        result_reg   <= result_next;
    end

`ifndef SYNTH
    // The level counter never leaves the table's jump levels inside a walk.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_I_ANC || state_reg == S_I_WR || state_reg == S_U_ANC ||
         state_reg == S_U_DEP || state_reg == S_U_CMP || state_reg == S_D_ANC ||
         state_reg == S_D_CMP) |-> (lvl_reg <= LVL_TOP))
    else $error("jump level out of range");

    // A result appears only when a finished query hands it over.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_DONE))
    else $error("result produced outside the hand-over step");

    // An insert of a real node walks every level and returns to idle on time.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && opcode == OP_INSERT && in_first != '0)
            |-> ##(2 * LEVELS + 3) (state_reg == S_IDLE))
    else $error("insert walk length mismatch");

    // A query never writes either store.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_Q_SWAP || state_reg == S_U_CMP || state_reg == S_D_CMP ||
         state_reg == S_F_OUT) |-> (!dep_we && !anc_we))
    else $error("store written during a query");
`endif

endmodule

/* sv/lcabl_ram.sv */
// Generic single-write, dual-read RAM with registered read data.
`timescale 1ns / 1ps
module lcabl_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr0,
    input  logic [$clog2(DEPTH)-1:0] raddr1,
    output logic [WIDTH-1:0]         rdata0,
    output logic [WIDTH-1:0]         rdata1
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata0 <= mem[raddr0];
        rdata1 <= mem[raddr1];
    end

endmodule

/* sv/lcabl_alu.sv */
// Shared compare and saturating-increment unit used by the steps of the sequencer.
`timescale 1ns / 1ps
module lcabl_alu (
    input  lcabl_pkg::alu_req_t req,
    output lcabl_pkg::alu_rsp_t rsp
);

    import lcabl_pkg::*;

    logic [NODE_W:0] diff;
    logic [NODE_W:0] incr;
    logic            borrow;
    logic            zero;

    // One subtractor serves all magnitude and equality tests.
    assign diff   = {1'b0, req.x} - {1'b0, req.y};
    assign incr   = {1'b0, req.x} + {{NODE_W{1'b0}}, 1'b1};
    assign borrow = diff[NODE_W];
    assign zero   = (diff[NODE_W-1:0] == '0);

    always_comb
    begin
        rsp.flag = 1'b0;
        rsp.sum  = req.x;
        case (req.op)
            ALU_INC:
            begin
                rsp.flag = incr[NODE_W];
                rsp.sum  = incr[NODE_W] ? req.x : incr[NODE_W-1:0];
            end
            ALU_LT: rsp.flag = borrow;
            ALU_GE: rsp.flag = !borrow;
            ALU_NE: rsp.flag = !zero;
            ALU_EQ: rsp.flag = zero;
            default:
            begin
                rsp.flag = 1'b0;
                rsp.sum  = req.x;
            end
        endcase
    end

endmodule

/* test/lca_binary_lifting_sb.sv */
// Scoreboard class for the lowest-common-ancestor test.
`timescale 1ns / 1ps
package lca_sb_pkg;

    import lcabl_pkg::*;

    localparam int TREE_NODES = NODES_DEF;
    localparam int JUMPS      = LEVELS_DEF + 1;

    class lca_scoreboard;

        logic [DEPTH_W-1:0] node_depth [TREE_NODES];
        logic [NODE_W-1:0]  jump_up [TREE_NODES][JUMPS];
        logic [NODE_W-1:0]  due_ancestors [$];
        int                 mismatches;

        function new();
            foreach (node_depth[i])
                node_depth[i] = '0;
            foreach (jump_up[i, k])
                jump_up[i][k] = '0;
            mismatches = 0;
        endfunction

        // Node numbers past the end of the tree fold onto the sentinel.
        function int unsigned as_node(logic [NODE_W-1:0] v);
            return (int'(v) < TREE_NODES) ? int'(v) : 0;
        endfunction

        function void add_child(int unsigned node, int unsigned parent);
            int unsigned d;
            int unsigned mid;
            int          k;
            if (node == 0)
                return;
            jump_up[node][0] = NODE_W'(parent);
            d = 32'(node_depth[parent]) + 1;
            if (d > 32'(DEPTH_MAX))
                d = 32'(DEPTH_MAX);
            node_depth[node] = d[DEPTH_W-1:0];
            for (k = 1; k < JUMPS; k++)
            begin
                mid = 32'(jump_up[node][k-1]);
                jump_up[node][k] = jump_up[mid][k-1];
            end
        endfunction

        function int unsigned meet_point(int unsigned a, int unsigned b);
            int unsigned t;
            int unsigned ua;
            int unsigned ub;
            int          k;
            if (node_depth[a] < node_depth[b])
            begin
                t = a;
                a = b;
                b = t;
            end
            for (k = JUMPS - 1; k >= 0; k--)
            begin
                ua = 32'(jump_up[a][k]);
                if (node_depth[ua] >= node_depth[b])
                    a = ua;
            end
            if (a == b)
                return a;
            for (k = JUMPS - 1; k >= 0; k--)
            begin
                ua = 32'(jump_up[a][k]);
                ub = 32'(jump_up[b][k]);
                if (ua != ub)
                begin
                    a = ua;
                    b = ub;
                end
            end
            return 32'(jump_up[a][0]);
        endfunction

        function void note_input(opcode_t op, logic [NODE_W-1:0] node_a,
                                 logic [NODE_W-1:0] node_b);
            if (op == OP_INSERT)
                add_child(as_node(node_a), as_node(node_b));
            else
                due_ancestors.insert(due_ancestors.size(),
                                     NODE_W'(meet_point(as_node(node_a), as_node(node_b))));
        endfunction

        function void check_result(logic [NODE_W-1:0] got);
            logic [NODE_W-1:0] want;
            if (due_ancestors.size() == 0)
            begin
                $error("ancestor: result %0d arrived with no query outstanding", got);
                mismatches++;
                return;
            end
            want = due_ancestors.pop_front();
            if (got !== want)
            begin
                $error("ancestor mismatch: expected %0d, actual %0d", want, got);
                mismatches++;
            end
        endfunction

        function int pending();
            return due_ancestors.size();
        endfunction

    endclass

endpackage

/* test/lca_binary_lifting_test.sv */
// Self-checking testbench for the binary-lifting lowest-common-ancestor block.
`timescale 1ns / 1ps
module lca_binary_lifting_test;

    import lcabl_pkg::*;
    import lca_sb_pkg::*;

    // The block sweeps its stores after reset, and nothing is accepted during
    // that sweep, so the watchdog must allow well beyond the sweep.
    localparam int WATCHDOG_LIMIT = 50000;
    // The drain waits longer than the slowest query takes.
    localparam int DRAIN_CYCLES   = 80;
    // A short run of self-inserts that stacks one node a few levels deeper.
    localparam int SELF_STEPS     = 8;

    logic              clk         = 1'b0;
    logic              rst_n       = 1'b0;
    logic              in_valid    = 1'b0;
    logic              in_stall;
    logic              opcode      = 1'b0;
    logic [NODE_W-1:0] first_node  = '0;
    logic [NODE_W-1:0] second_node = '0;
    logic              out_valid;
    logic              out_stall   = 1'b0;
    logic [NODE_W-1:0] ancestor;

    // Idle rates in percent for the sender and the receiver.
    int send_idle  = 0;
    int recv_stall = 0;
    int idle_cycles = 0;

    // Nodes that the stimulus has inserted, used to build well-formed trees.
    bit                in_tree [TREE_NODES];
    logic [NODE_W-1:0] tree_nodes [$];

    lca_scoreboard sb = new();

    lca_binary_lifting dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .opcode     (opcode),
        .first_node (first_node),
        .second_node(second_node),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .ancestor   (ancestor)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // The receiver stalls at random; a rate of zero gives long clean stretches.
    always @(posedge clk)
        out_stall <= ($urandom_range(99) < recv_stall);

    // Both channels are sampled at the clock edge, before the block's registers
    // move, so each accepted transaction is seen exactly as the block saw it.
    // The input side is noted first: a result can never belong to a query that
    // is accepted in the same cycle.
    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && in_valid === 1'b1 && in_stall === 1'b0)
            sb.note_input(opcode_t'(opcode), first_node, second_node);
        if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0)
            sb.check_result(ancestor);
    end

    // The watchdog counts cycles in which neither channel moves a transaction.
    always @(posedge clk)
    begin
        if ((in_valid === 1'b1 && in_stall === 1'b0) ||
            (out_valid === 1'b1 && out_stall === 1'b0))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("lca_binary_lifting test failed");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // Presents one transaction and returns at the edge where it is accepted.
    // Valid is raised only after the random idle gap and then held, with the
    // payload, until the block takes it.
    task automatic send_item(input opcode_t op, input logic [NODE_W-1:0] node_a,
                             input logic [NODE_W-1:0] node_b);
        while ($urandom_range(99) < send_idle)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        opcode      <= op;
        first_node  <= node_a;
        second_node <= node_b;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
    endtask

    // Inserts a node and remembers it as a tree member the first time.
    task automatic add_node(input logic [NODE_W-1:0] node,
                            input logic [NODE_W-1:0] parent);
        send_item(OP_INSERT, node, parent);
        if (node != 0 && !in_tree[node])
        begin
            in_tree[node] = 1'b1;
            tree_nodes.insert(tree_nodes.size(), node);
        end
    endtask

    // Half the picks come from the most recent inserts, so that new children
    // hang under deep nodes and the tree grows long chains worth lifting over.
    function automatic logic [NODE_W-1:0] pick_member();
        int span;
        if (tree_nodes.size() == 0)
            return NODE_W'($urandom);
        if ($urandom_range(1) == 0)
        begin
            span = (tree_nodes.size() < 8) ? tree_nodes.size() : 8;
            return tree_nodes[tree_nodes.size() - 1 - $urandom_range(span - 1)];
        end
        return tree_nodes[$urandom_range(tree_nodes.size() - 1)];
    endfunction

    function automatic logic [NODE_W-1:0] fresh_node();
        logic [NODE_W-1:0] node;
        int                tries;
        tries = 0;
        do
        begin
            node = NODE_W'($urandom_range(TREE_NODES - 1, 1));
            tries++;
        end
        while (in_tree[node] && tries < 64);
        return node;
    endfunction

    // Mostly well-formed growth of the tree and queries between its members;
    // the rest is noise: reinserts, unknown parents and arbitrary node numbers.
    // Inserts of the sentinel are ignored by the block and do not count.
    task automatic random_phase(input int sender_rate, input int receiver_rate,
                                input int items);
        int n;
        int r;
        n = 0;
        send_idle  = sender_rate;
        recv_stall <= receiver_rate;
        while (n < items)
        begin
            r = $urandom_range(99);
            n++;
            if (r < 45)
                add_node(fresh_node(), ($urandom_range(99) < 8) ? '0 : pick_member());
            else if (r < 86)
                send_item(OP_QUERY, pick_member(), pick_member());
            else if (r < 91)
                add_node(NODE_W'($urandom), NODE_W'($urandom));
            else if (r < 94)
            begin
                send_item(OP_INSERT, '0, NODE_W'($urandom));
                n--;
            end
            else
                send_item(OP_QUERY, NODE_W'($urandom), NODE_W'($urandom));
        end
    endtask

    initial
    begin
        logic [NODE_W-1:0] deep_node;
        int                k;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        wait (rst_n === 1'b1);
        @(posedge clk);

        // Directed part on an empty and then a small hand-built tree.
        send_item(OP_QUERY, '0, '0);
        add_node(10'd1, '0);
        add_node(10'd2, 10'd1);
        add_node(10'd3, 10'd1);
        add_node(10'd4, 10'd2);
        add_node(10'd1023, 10'd4);
        add_node(10'd5, 10'd3);
        // The sentinel must never be overwritten.
        send_item(OP_INSERT, '0, 10'd1023);
        // Cousins under the root, then ancestor and descendant both ways.
        send_item(OP_QUERY, 10'd4, 10'd5);
        send_item(OP_QUERY, 10'd1023, 10'd2);
        send_item(OP_QUERY, 10'd2, 10'd1023);
        send_item(OP_QUERY, 10'd3, 10'd3);
        send_item(OP_QUERY, 10'd1023, 10'd1023);
        // The sentinel takes part in queries like any node.
        send_item(OP_QUERY, '0, 10'd4);
        send_item(OP_QUERY, 10'd1023, '0);
        // A node that was never inserted reads as a cleared row.
        send_item(OP_QUERY, 10'd6, 10'd4);
        // A parent that is not in the tree yet, then a reinsert elsewhere.
        add_node(10'd7, 10'd900);
        send_item(OP_QUERY, 10'd7, 10'd5);
        add_node(10'd5, 10'd4);
        send_item(OP_QUERY, 10'd5, 10'd1023);
        send_item(OP_QUERY, 10'd682, 10'd341);

        random_phase(0, 0, 125);
        random_phase(74, 0, 125);
        random_phase(0, 74, 125);
        random_phase(26, 26, 125);

        // A node that is its own parent gains one level per insert.
        send_idle  = 0;
        recv_stall <= 0;
        deep_node = fresh_node();
        add_node(deep_node, pick_member());
        for (k = 0; k < SELF_STEPS; k++)
            add_node(deep_node, deep_node);
        send_item(OP_QUERY, deep_node, deep_node);
        send_item(OP_QUERY, deep_node, '0);
        for (k = 0; k < 6; k++)
            send_item(OP_QUERY, pick_member(), deep_node);

        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        // Extra time lets any stray result show up before the verdict.
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("lca_binary_lifting test passed");
        else
            $display("lca_binary_lifting test failed");
        $finish;
    end

endmodule
